// File: design/shm_pkg.sv
// shm_pkg: shared types, register codes and helpers for the string hash hex unit
// depends on nothing; used by shm_ctrl, shm_datapath and the top level
package shm_pkg;

    // configuration register indexes
    localparam logic REG_MODULUS = 1'b0;
    localparam logic REG_PAD     = 1'b1;

    localparam int HASH_W   = 28;
    localparam int MOD_W    = 32;
    localparam int PAD_W    = 5;
    localparam int DIGIT_W  = 7;
    localparam int HASH_NIB = HASH_W / 4;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_PREP,
        ST_EMIT
    } shm_state_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic load_value;
        logic div_step;
        logic prep;
        logic emit;
    } shm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mod_zero;
        logic div_last;
        logic pos_last;
        logic out_free;
    } shm_status_t;

    // one ELF/PJW step: shift in a byte, fold the top nibble back down
    function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                   input logic [7:0] c);
        logic [31:0] sum;
        sum = {h, 4'h0} + {24'h0, c};
        return {sum[27:8], sum[7:4] ^ sum[31:28], sum[3:0]};
    endfunction

    // lowercase ascii hex digit
    function automatic logic [DIGIT_W-1:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10)
            return 7'h30 + {3'b000, nib};
        else
            return 7'h57 + {3'b000, nib};
    endfunction

endpackage

// File: design/shm_ctrl.sv
// shm_ctrl: sequencing state machine for the string hash hex unit
// depends on shm_pkg; drives shm_datapath through command and status structs
module shm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tlast,
    output logic                 s_tready,
    input  shm_pkg::shm_status_t status,
    output shm_pkg::shm_cmd_t    cmd
);

    shm_pkg::shm_state_t state_reg;
    shm_pkg::shm_state_t state_next;
    logic                take;

    assign take = s_tvalid && (state_reg == shm_pkg::ST_IDLE);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= shm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            shm_pkg::ST_IDLE:
            begin
                if (take && s_tlast)
                    state_next = status.mod_zero ? shm_pkg::ST_PREP : shm_pkg::ST_DIVIDE;
            end
            shm_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                    state_next = shm_pkg::ST_PREP;
            end
            shm_pkg::ST_PREP:
            begin
                state_next = shm_pkg::ST_EMIT;
            end
            shm_pkg::ST_EMIT:
            begin
                if (status.out_free && status.pos_last)
                    state_next = shm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = shm_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready       = 1'b0;
        cmd.take_item  = 1'b0;
        cmd.load_value = 1'b0;
        cmd.div_step   = 1'b0;
        cmd.prep       = 1'b0;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            shm_pkg::ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.take_item  = take;
                cmd.load_value = take && s_tlast;
            end
            shm_pkg::ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            shm_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            shm_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// File: design/shm_datapath.sv
// shm_datapath: hash fold, bit-serial modulo, digit count and output register
// depends on shm_pkg; commanded by shm_ctrl
module shm_datapath #(
    parameter int MAX_TEXT_CHARS = 19
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [shm_pkg::MOD_W-1:0]          cfg_data,
    input  logic [7:0]                         char_byte,
    input  logic                               no_char,
    input  logic                               end_of_string,
    input  shm_pkg::shm_cmd_t                  cmd,
    output shm_pkg::shm_status_t               status,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [shm_pkg::DIGIT_W-1:0]        hex_char,
    output logic                               last_char
);

    localparam int POS_W = $clog2(MAX_TEXT_CHARS);
    localparam int CNT_W = $clog2(shm_pkg::HASH_W);
    localparam logic [shm_pkg::PAD_W-1:0] PAD_MAX = shm_pkg::PAD_W'(MAX_TEXT_CHARS);

    logic [shm_pkg::MOD_W-1:0]   mod_reg;
    logic [shm_pkg::PAD_W-1:0]   pad_reg;
    logic [shm_pkg::HASH_W-1:0]  hash_reg;
    logic                        zero_reg;
    logic [shm_pkg::HASH_W-1:0]  quot_reg;
    logic [shm_pkg::MOD_W-1:0]   rem_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [shm_pkg::HASH_W-1:0]  value_reg;
    logic [POS_W-1:0]            pos_reg;
    logic                        valid_reg;
    logic [shm_pkg::DIGIT_W-1:0] char_reg;
    logic                        last_reg;

    logic                        fold_en;
    logic [shm_pkg::HASH_W-1:0]  hash_next;
    logic [shm_pkg::MOD_W:0]     rem_shift;
    logic [shm_pkg::MOD_W+1:0]   diff;
    logic [shm_pkg::MOD_W-1:0]   rem_next;
    logic [2:0]                  ndig;
    logic [shm_pkg::PAD_W-1:0]   pad_sat;
    logic [shm_pkg::PAD_W-1:0]   width;
    logic [3:0]                  nib;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= '0;
            pad_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                shm_pkg::REG_MODULUS: mod_reg <= cfg_data;
                shm_pkg::REG_PAD:     pad_reg <= cfg_data[shm_pkg::PAD_W-1:0];
                default:              mod_reg <= mod_reg;
            endcase
        end
    end

    // byte fold, skipped after an embedded zero byte
    assign fold_en   = !no_char && !zero_reg && (char_byte != 8'h00);
    assign hash_next = fold_en ? shm_pkg::fold_byte(hash_reg, char_byte) : hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= '0;
            zero_reg <= 1'b0;
        end
        else if (cmd.take_item)
        begin
            if (end_of_string)
            begin
                hash_reg <= '0;
                zero_reg <= 1'b0;
            end
            else
            begin
                hash_reg <= hash_next;
                zero_reg <= zero_reg || (!no_char && (char_byte == 8'h00));
            end
        end
    end

    // restoring division step, one quotient bit per cycle
    assign rem_shift = {rem_reg, quot_reg[shm_pkg::HASH_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, mod_reg};
    assign rem_next  = diff[shm_pkg::MOD_W+1] ? rem_shift[shm_pkg::MOD_W-1:0]
                                              : diff[shm_pkg::MOD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.load_value)
            cnt_reg <= CNT_W'(shm_pkg::HASH_W - 1);
        else if (cmd.div_step)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_value)
        begin
            quot_reg  <= hash_next;
            rem_reg   <= '0;
            value_reg <= hash_next;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[shm_pkg::HASH_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            if (cnt_reg == '0)
                value_reg <= rem_next[shm_pkg::HASH_W-1:0];
        end
    end

    // significant digit count and padded text width
    always_comb
    begin
        ndig = 3'd1;
        for (int i = 1; i < shm_pkg::HASH_NIB; i++)
        begin
            if ((value_reg >> (4 * i)) != '0)
                ndig = 3'(i + 1);
        end
        pad_sat = (pad_reg > PAD_MAX) ? PAD_MAX : pad_reg;
        width   = ({2'b00, ndig} > pad_sat) ? {2'b00, ndig} : pad_sat;
    end

    // digit position, counts down to the least significant digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (cmd.prep)
            pos_reg <= POS_W'(width - 1'b1);
        else if (cmd.emit)
            pos_reg <= pos_reg - 1'b1;
    end

    assign nib = 4'(value_reg >> {pos_reg, 2'b00});

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= shm_pkg::hex_ascii(nib);
            last_reg <= (pos_reg == '0);
        end
    end

    assign out_valid = valid_reg;
    assign hex_char  = char_reg;
    assign last_char = last_reg;

    // status back to the controller
    assign status.mod_zero = (mod_reg == '0);
    assign status.div_last = (cnt_reg == '0);
    assign status.pos_last = (pos_reg == '0);
    assign status.out_free = !valid_reg || out_ready;

endmodule

// File: design/string_hash_mod_hex_unit.sv
// string_hash_mod_hex_unit: ELF/PJW string hash, optional modulo, padded hex text
// sequence: byte transfers are folded into the hash while idle; after the end-of-string transfer,
// bit-serial modulo (none when modulus is zero), a setup state, then one hex
// character per cycle while the output side takes them
// a new string is taken only after the last hex character has been loaded into the output register
// reset: rst_n asynchronous active low clears hash, controller, output valid and config registers
module string_hash_mod_hex_unit #(
    parameter int MAX_TEXT_CHARS = 19
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tuser,   // [0] no_char
    input  logic        s_axis_tlast,   // end_of_string
    // hex text out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] hex_char, [7] zero
    output logic        m_axis_tlast    // last_char
);

    shm_pkg::shm_cmd_t              cmd;
    shm_pkg::shm_status_t           status;
    logic [shm_pkg::DIGIT_W-1:0]    hex_char;

    // controller
    shm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tlast  (s_axis_tlast),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    shm_datapath #(
        .MAX_TEXT_CHARS (MAX_TEXT_CHARS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .char_byte     (s_axis_tdata),
        .no_char       (s_axis_tuser),
        .end_of_string (s_axis_tlast),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .hex_char      (hex_char),
        .last_char     (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, hex_char};

endmodule

// File: design/shm_checker.sv
// shm_checker: port-level checks for string_hash_mod_hex_unit
// depends on the top level's ports only; bound to the top level below
module shm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // a stalled output transfer holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // only lowercase hex digits leave the block
    a_hex_digit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
            (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h66))
        else $error("output is not a lowercase hex digit");

    // end of string stops intake while the text is produced
    a_busy_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after end of string");

    // no new text comes out while bytes are still being taken
    a_no_text_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && $past(s_axis_tready) |-> !m_axis_tvalid || !$past(m_axis_tready)
            || $past(m_axis_tvalid) && !$rose(m_axis_tvalid))
        else $error("output produced while idle");

endmodule

bind string_hash_mod_hex_unit shm_checker u_shm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
